FILE: hdl/ctes_pkg.sv
// ----------------------------------------------------------------------------
// ctes_pkg
// Types, constants and month tables for the civil time to epoch seconds
// pipeline.
// ----------------------------------------------------------------------------
package ctes_pkg;

	localparam logic [15:0] BASE_YEAR   = 16'd1900;
	localparam logic [14:0] RECIP_25    = 15'd20972;     // ceil(2^19 / 25)
	localparam int          RECIP_25_SH = 19;
	localparam logic [24:0] RECIP_7     = 25'd19173962;  // ceil(2^27 / 7)
	localparam int          RECIP_7_SH  = 27;
	localparam logic signed [25:0] DAYS_0000_TO_1970 = 26'sd719468;
	localparam logic signed [17:0] SECS_PER_DAY      = 18'sd86400;
	localparam logic [6:0]  MONTH_MAX  = 7'd11;
	localparam logic [6:0]  DAY_MAX    = 7'd31;
	localparam logic [6:0]  HOUR_MAX   = 7'd23;
	localparam logic [6:0]  MINUTE_MAX = 7'd59;
	localparam logic [6:0]  SECOND_MAX = 7'd60;
	localparam logic [3:0]  MARCH      = 4'd2;

	typedef struct packed {
		logic signed [15:0] year;
		logic signed [7:0]  month;
		logic signed [7:0]  day;
		logic signed [7:0]  hour;
		logic signed [7:0]  minute;
		logic signed [7:0]  second;
	} raw_t;

	typedef struct packed {
		logic [14:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} clamp_t;

	typedef struct packed {
		clamp_t      clp;
		logic [15:0] yy;
		logic        early;
	} s1_t;

	typedef struct packed {
		clamp_t             clp;
		logic [3:0]         yy_lo;
		logic               early;
		logic [13:0]        q4;
		logic [11:0]        q16;
		logic [9:0]         q100;
		logic [7:0]         q400;
		logic [23:0]        y365;
		logic [16:0]        secs;
		logic signed [9:0]  doy;
		logic signed [9:0]  ydb;
	} s2_t;

	typedef struct packed {
		clamp_t             clp;
		logic signed [25:0] days;
		logic [16:0]        secs;
		logic [9:0]         year_day;
	} s3_t;

	typedef struct packed {
		clamp_t             clp;
		logic signed [41:0] prod;
		logic [16:0]        secs;
		logic [23:0]        wv;
		logic [21:0]        wq;
		logic [9:0]         year_day;
	} s4_t;

	typedef struct packed {
		clamp_t      clp;
		logic [40:0] epoch;
		logic        ovf;
		logic [2:0]  weekday;
		logic [9:0]  year_day;
	} res_t;

	function automatic logic [6:0] clamp_u(input logic signed [7:0] v, input logic [6:0] hi);
		if (v[7])
			return 7'd0;
		else if (v[6:0] > hi)
			return hi;
		else
			return v[6:0];
	endfunction

	// day offset of the month start in a year that begins in March
	function automatic logic [8:0] mar_ofs(input logic [3:0] mo);
		case (mo)
			4'd0:    return 9'd306;
			4'd1:    return 9'd337;
			4'd2:    return 9'd0;
			4'd3:    return 9'd31;
			4'd4:    return 9'd61;
			4'd5:    return 9'd92;
			4'd6:    return 9'd122;
			4'd7:    return 9'd153;
			4'd8:    return 9'd184;
			4'd9:    return 9'd214;
			4'd10:   return 9'd245;
			4'd11:   return 9'd275;
			default: return 9'd0;
		endcase
	endfunction

	// days before the month start in a common year
	function automatic logic [8:0] cum_days(input logic [3:0] mo);
		case (mo)
			4'd0:    return 9'd0;
			4'd1:    return 9'd31;
			4'd2:    return 9'd59;
			4'd3:    return 9'd90;
			4'd4:    return 9'd120;
			4'd5:    return 9'd151;
			4'd6:    return 9'd181;
			4'd7:    return 9'd212;
			4'd8:    return 9'd243;
			4'd9:    return 9'd273;
			4'd10:   return 9'd304;
			4'd11:   return 9'd334;
			default: return 9'd0;
		endcase
	endfunction

endpackage

FILE: hdl/ctes_clamp.sv
// ----------------------------------------------------------------------------
// ctes_clamp
// Stage 1: clamps the date and time fields and forms the March-based year.
// ----------------------------------------------------------------------------
module ctes_clamp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ctes_pkg::raw_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ctes_pkg::s1_t   out_data
);

	logic          vld_s1;
	ctes_pkg::s1_t dat_s1;
	ctes_pkg::s1_t nxt;

	always_comb begin
		nxt.clp.year   = in_data.year[15] ? 15'd0 : in_data.year[14:0];
		nxt.clp.month  = 4'(ctes_pkg::clamp_u(in_data.month, ctes_pkg::MONTH_MAX));
		nxt.clp.day    = 5'(ctes_pkg::clamp_u(in_data.day, ctes_pkg::DAY_MAX));
		nxt.clp.hour   = 5'(ctes_pkg::clamp_u(in_data.hour, ctes_pkg::HOUR_MAX));
		nxt.clp.minute = 6'(ctes_pkg::clamp_u(in_data.minute, ctes_pkg::MINUTE_MAX));
		nxt.clp.second = 6'(ctes_pkg::clamp_u(in_data.second, ctes_pkg::SECOND_MAX));
		nxt.early      = nxt.clp.month < ctes_pkg::MARCH;
		nxt.yy         = {1'b0, nxt.clp.year} + ctes_pkg::BASE_YEAR - {15'd0, nxt.early};
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dat_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = dat_s1;

endmodule

FILE: hdl/ctes_days.sv
// ----------------------------------------------------------------------------
// ctes_days
// Stages 2 and 3: century terms by reciprocal multiply, day count since the
// epoch, seconds of day and day of year.
// ----------------------------------------------------------------------------
module ctes_days (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ctes_pkg::s1_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ctes_pkg::s3_t   out_data
);

	logic          vld_s2;
	logic          vld_s3;
	logic          rdy_s3;
	ctes_pkg::s2_t dat_s2;
	ctes_pkg::s3_t dat_s3;
	ctes_pkg::s2_t nxt2;
	ctes_pkg::s3_t nxt3;
	logic [28:0]   p100;
	logic [26:0]   p400;
	logic [13:0]   t100;
	logic [11:0]   t400;
	logic          div100;
	logic          div400;
	logic          leap;

	// stage 2
	always_comb begin
		nxt2.clp   = in_data.clp;
		nxt2.yy_lo = in_data.yy[3:0];
		nxt2.early = in_data.early;
		nxt2.q4    = in_data.yy[15:2];
		nxt2.q16   = in_data.yy[15:4];
		p100       = 29'(nxt2.q4) * 29'(ctes_pkg::RECIP_25);
		p400       = 27'(nxt2.q16) * 27'(ctes_pkg::RECIP_25);
		nxt2.q100  = p100[ctes_pkg::RECIP_25_SH +: 10];
		nxt2.q400  = p400[ctes_pkg::RECIP_25_SH +: 8];
		nxt2.y365  = 24'(in_data.yy) * 24'd365;
		nxt2.secs  = 17'(in_data.clp.hour) * 17'd3600 + 17'(in_data.clp.minute) * 17'd60
			+ 17'(in_data.clp.second);
		nxt2.doy   = $signed({1'b0, ctes_pkg::mar_ofs(in_data.clp.month)})
			+ $signed({5'd0, in_data.clp.day}) - 10'sd1;
		nxt2.ydb   = $signed({1'b0, ctes_pkg::cum_days(in_data.clp.month)})
			+ $signed({5'd0, in_data.clp.day}) - 10'sd1;
	end

	assign rdy_s3   = !vld_s3 || out_ready;
	assign in_ready = !vld_s2 || rdy_s3;

	// stage 3
	always_comb begin
		t100   = {dat_s2.q100[9:0], 4'd0} + {1'b0, dat_s2.q100, 3'd0} + {4'd0, dat_s2.q100};
		t400   = {dat_s2.q400, 4'd0} + {1'b0, dat_s2.q400, 3'd0} + {4'd0, dat_s2.q400};
		div100 = (dat_s2.yy_lo[1:0] == 2'd0) && (dat_s2.q4 == t100);
		div400 = (dat_s2.yy_lo == 4'd0) && (dat_s2.q16 == t400);
		leap   = (dat_s2.yy_lo[1:0] == 2'd0) && (!div100 || div400);
		nxt3.clp      = dat_s2.clp;
		nxt3.secs     = dat_s2.secs;
		nxt3.year_day = 10'(dat_s2.ydb) + {9'd0, leap && !dat_s2.early};
		nxt3.days     = $signed({2'd0, dat_s2.y365}) + $signed({12'd0, dat_s2.q4})
			- $signed({16'd0, dat_s2.q100}) + $signed({18'd0, dat_s2.q400})
			+ $signed({{16{dat_s2.doy[9]}}, dat_s2.doy}) - ctes_pkg::DAYS_0000_TO_1970;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s2 <= in_valid;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dat_s2 <= nxt2;
		end
		if (rdy_s3 && vld_s2) begin
			dat_s3 <= nxt3;
		end
	end

	assign out_valid = vld_s3;
	assign out_data  = dat_s3;

endmodule

FILE: hdl/ctes_finish.sv
// ----------------------------------------------------------------------------
// ctes_finish
// Stages 4 and 5: day-to-second product, weekday by reciprocal multiply,
// before-epoch check. Stage 5 is the output register.
// ----------------------------------------------------------------------------
module ctes_finish (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ctes_pkg::s3_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ctes_pkg::res_t  out_data
);

	logic               vld_s4;
	logic               vld_s5;
	logic               rdy_s5;
	ctes_pkg::s4_t      dat_s4;
	ctes_pkg::res_t     dat_s5;
	ctes_pkg::s4_t      nxt4;
	ctes_pkg::res_t     nxt5;
	logic signed [43:0] prod_w;
	logic [48:0]        wq_w;
	logic signed [41:0] total;
	logic [24:0]        rem_w;

	// stage 4
	always_comb begin
		prod_w        = in_data.days * ctes_pkg::SECS_PER_DAY;
		nxt4.clp      = in_data.clp;
		nxt4.prod     = prod_w[41:0];
		nxt4.secs     = in_data.secs;
		nxt4.year_day = in_data.year_day;
		nxt4.wv       = in_data.days[23:0] + 24'd4;  // epoch day was a Thursday
		wq_w          = 49'(nxt4.wv) * 49'(ctes_pkg::RECIP_7);
		nxt4.wq       = wq_w[ctes_pkg::RECIP_7_SH +: 22];
	end

	assign rdy_s5   = !vld_s5 || out_ready;
	assign in_ready = !vld_s4 || rdy_s5;

	// stage 5
	always_comb begin
		total = dat_s4.prod + $signed({25'd0, dat_s4.secs});
		rem_w = {1'b0, dat_s4.wv} - ({dat_s4.wq, 3'd0} - {3'd0, dat_s4.wq});
		nxt5.clp      = dat_s4.clp;
		nxt5.ovf      = total[41];
		nxt5.epoch    = total[41] ? 41'd0 : total[40:0];
		nxt5.weekday  = total[41] ? 3'd0 : rem_w[2:0];
		nxt5.year_day = total[41] ? 10'd0 : dat_s4.year_day;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s4 <= in_valid;
			end
			if (rdy_s5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dat_s4 <= nxt4;
		end
		if (rdy_s5 && vld_s4) begin
			dat_s5 <= nxt5;
		end
	end

	assign out_valid = vld_s5;
	assign out_data  = dat_s5;

endmodule

FILE: hdl/civil_time_to_epoch_seconds_top.sv
// ----------------------------------------------------------------------------
// civil_time_to_epoch_seconds_top
// Gregorian date and time to seconds since 1970-01-01, five-stage pipeline.
// ----------------------------------------------------------------------------
// Input beat on s_*: year offset from 1900 and month, day, hour, minute,
// second, all two's complement. Each input beat yields exactly one output
// beat on m_*: epoch seconds, weekday, day of year and the clamped fields,
// with the before-epoch flag in m_tuser.
// Each beat passes the registers of stages 1 to 5 in order and is offered on
// m_* from the stage 5 register.
// Throughput: one beat per cycle; every stage holds one beat and carries its
// own valid bit, so a new beat enters each cycle while the output flows.
// Stage 1 clamps, stage 2 runs the reciprocal multiplies for the century
// terms, stage 3 sums the day count, stage 4 multiplies by seconds per day
// and by the reciprocal of 7, stage 5 adds and registers the result.
// Reset clears all valid bits; the data registers are not reset.
// When m_tready is low, beats pile up into empty stages; s_tready drops only
// once all five stages hold a beat. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module civil_time_to_epoch_seconds_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// year_offset[15:0], month_in[23:16], day_in[31:24], hour_in[39:32],
	// minute_in[47:40], second_in[55:48]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// epoch_seconds[40:0], weekday[43:41], year_day[53:44], year_clamped[68:54],
	// month_clamped[72:69], day_clamped[77:73], hour_clamped[82:78],
	// minute_clamped[88:83], second_clamped[94:89], zero[95]
	output logic [95:0] m_tdata,
	// overflow[0]
	output logic [0:0]  m_tuser
);

	ctes_pkg::raw_t raw;
	ctes_pkg::s1_t  d1;
	ctes_pkg::s3_t  d3;
	ctes_pkg::res_t res;
	logic           v1;
	logic           r1;
	logic           v3;
	logic           r3;

	assign raw.year   = s_tdata[15:0];
	assign raw.month  = s_tdata[23:16];
	assign raw.day    = s_tdata[31:24];
	assign raw.hour   = s_tdata[39:32];
	assign raw.minute = s_tdata[47:40];
	assign raw.second = s_tdata[55:48];

	ctes_clamp u_clamp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (raw),
		.out_valid (v1),
		.out_ready (r1),
		.out_data  (d1)
	);

	ctes_days u_days (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.in_data   (d1),
		.out_valid (v3),
		.out_ready (r3),
		.out_data  (d3)
	);

	ctes_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v3),
		.in_ready  (r3),
		.in_data   (d3),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	assign m_tdata = {1'b0, res.clp.second, res.clp.minute, res.clp.hour, res.clp.day,
		res.clp.month, res.clp.year, res.year_day, res.weekday, res.epoch};
	assign m_tuser = res.ovf;

`ifndef NO_ASSERTIONS
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[53:0] == 54'd0)
		else $error("before-epoch beat carries nonzero time fields");

	a_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[43:41] != 3'd7)
		else $error("weekday out of range");

	a_month: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[72:69] <= 4'd11)
		else $error("clamped month out of range");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready && v1 && v3)
		else $error("input stalled while the pipeline has room");
`endif

endmodule
